>>> hdl/double_to_custom_float_macros.svh
// Assertion macros shared by the converter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef DOUBLE_TO_CUSTOM_FLOAT_MACROS_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define D2CF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define D2CF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/d2cf_pkg.sv
// Shared types and constants for the double to custom float converter.
// No dependencies.
`default_nettype none
package d2cf_pkg;
    localparam int unsigned DBL_W = 64;
    localparam int unsigned TW_W  = 7;
    localparam int unsigned EW_W  = 6;
    localparam logic [10:0] DBL_EXP_ALL_ONES = 11'd2047;
    localparam logic [11:0] DBL_BIAS = 12'd1023;
    localparam logic [6:0]  DBL_SIG_BITS = 7'd53;

    // Register indexes of the configuration port
    localparam logic [0:0] REG_TOTAL_WIDTH    = 1'b0;
    localparam logic [0:0] REG_EXPONENT_WIDTH = 1'b1;

    typedef struct packed {
        logic [63:0] double_bits;
    } t_in_item;

    typedef struct packed {
        logic [63:0] packed_value;
        logic        width_error;
    } t_out_item;
endpackage
`default_nettype wire

>>> hdl/d2cf_in_if.sv
// Input channel interface: valid/ready with one double per transaction.
// Depends on d2cf_pkg.
`default_nettype none
interface d2cf_in_if;
    logic              valid;
    logic              ready;
    d2cf_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/d2cf_out_if.sv
// Output channel interface: valid/ready with one packed result per transaction.
// Depends on d2cf_pkg.
`default_nettype none
interface d2cf_out_if;
    logic               valid;
    logic               ready;
    d2cf_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/double_to_custom_float.sv
// Top level of the double to custom float converter.
// Depends on d2cf_pkg, d2cf_in_if, d2cf_out_if and the macros header.
//
// Converts a binary64 pattern into a float of configurable total and exponent
// width, truncating the fraction. Four register stages (field split and width
// check, rebias, classify, pack); one transaction accepted per cycle unless the
// output stalls. Each result passes the stages in that order and is presented
// from the pack stage. The pipeline advances as one unit when the last stage is
// empty or being taken, so a stall holds every stage.
// Write configuration only while the pipeline is empty.
`default_nettype none
`include "double_to_custom_float_macros.svh"
module double_to_custom_float (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire  [0:0]   i_cfg_index,
    input  wire  [6:0]   i_cfg_data,
    d2cf_in_if.sink      i_in,
    d2cf_out_if.source   o_out
);
    logic [6:0] r_tw;
    logic [5:0] r_ew;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw <= 7'd32;
            r_ew <= 6'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                d2cf_pkg::REG_TOTAL_WIDTH:    r_tw <= i_cfg_data;
                d2cf_pkg::REG_EXPONENT_WIDTH: r_ew <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;
    assign adv = !r_v4 || o_out.ready;
    assign i_in.ready = adv;

    // Stage 1: split fields, check widths, work out derived widths
    logic        r1_err, r1_sign, r1_fnz;
    logic [10:0] r1_dexp;
    logic [51:0] r1_frac;
    logic [5:0]  r1_ew;
    logic [6:0]  r1_tme, r1_tw;
    logic        n1_err;
    always_comb begin
        n1_err = (r_tw < 7'd3) || (r_tw > 7'd64) || (r_ew < 6'd1)
            || ({1'b0, r_ew} > (r_tw - 7'd2));
    end

    // Stage 2: rebias as signed 64-bit-safe value
    logic        r2_err, r2_sign, r2_fnz, r2_inf, r2_zero;
    logic [51:0] r2_frac;
    logic [6:0]  r2_tme, r2_tw;
    logic signed [63:0] r2_re;
    logic [62:0] r2_allones;
    logic [62:0] n2_bias;
    assign n2_bias = (63'd1 << (r1_ew - 6'd1)) - 63'd1;

    // Stage 3: classify and align fraction
    logic        r3_err, r3_sign;
    logic [62:0] r3_nexp;
    logic [63:0] r3_frac;
    logic [5:0]  r3_fbits;
    logic [6:0]  r3_tw;
    logic [62:0] n3_nexp;
    logic [63:0] n3_frac;
    always_comb begin
        n3_nexp = '0;
        n3_frac = '0;
        if (r2_inf) begin
            n3_nexp = r2_allones;
            n3_frac = {63'd0, r2_fnz};
        end else if (r2_zero || r2_re < 64'sd1) begin
            n3_nexp = '0;
        end else if (r2_re > $signed({1'b0, r2_allones - 63'd1})) begin
            n3_nexp = r2_allones;
        end else begin
            n3_nexp = r2_re[62:0];
            if (r2_tme < d2cf_pkg::DBL_SIG_BITS)
                n3_frac = {12'd0, r2_frac} >> (d2cf_pkg::DBL_SIG_BITS - r2_tme);
            else
                n3_frac = {12'd0, r2_frac} << (r2_tme - d2cf_pkg::DBL_SIG_BITS);
        end
    end

    // Stage 4: pack
    logic [63:0] r4_val;
    logic        r4_err;
    logic [63:0] n4_val;
    logic [63:0] n4_sgn;
    always_comb begin
        n4_sgn = {63'd0, r3_sign} << (r3_tw - 7'd1);
        n4_val = r3_frac | ({1'b0, r3_nexp} << r3_fbits) | n4_sgn;
        if (r3_err) n4_val = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_err  <= n1_err;
            r1_sign <= i_in.payload.double_bits[63];
            r1_dexp <= i_in.payload.double_bits[62:52];
            r1_frac <= i_in.payload.double_bits[51:0];
            r1_fnz  <= |i_in.payload.double_bits[51:0];
            r1_ew   <= r_ew;
            r1_tw   <= r_tw;
            r1_tme  <= r_tw - {1'b0, r_ew};

            r2_err  <= r1_err;
            r2_sign <= r1_sign;
            r2_fnz  <= r1_fnz;
            r2_frac <= r1_frac;
            r2_tw   <= r1_tw;
            r2_tme  <= r1_tme;
            r2_inf  <= (r1_dexp == d2cf_pkg::DBL_EXP_ALL_ONES);
            r2_zero <= (r1_dexp == 11'd0);
            r2_re   <= $signed({53'd0, r1_dexp}) - $signed({52'd0, d2cf_pkg::DBL_BIAS})
                       + $signed({1'b0, n2_bias});
            r2_allones <= (63'd1 << r1_ew) - 63'd1;

            r3_err   <= r2_err;
            r3_sign  <= r2_sign;
            r3_nexp  <= n3_nexp;
            r3_frac  <= n3_frac;
            r3_fbits <= 6'(r2_tme - 7'd1);
            r3_tw    <= r2_tw;

            r4_val <= n4_val;
            r4_err <= r3_err;
        end
    end

    assign o_out.valid = r_v4;
    assign o_out.payload.packed_value = r4_val;
    assign o_out.payload.width_error  = r4_err;

    `D2CF_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, r_v4 && r4_err, r4_val == 64'd0,
        "width error with nonzero result")
    `D2CF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v4 && !o_out.ready,
        r_v4 && $stable(r4_val) && $stable(r4_err), "stalled result changed")
    `D2CF_ASSERT_NEXT(a_flow, i_clk, i_rst_n, adv && r_v3, r_v4,
        "stage three transaction lost")
endmodule
`default_nettype wire
